FILE: src/lmsh_pkg.sv
// Shared constants, types and the Hilbert coefficient table for the LMS filter block.
package lmsh_pkg;

  localparam int TAPS_DEF    = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 32;
  localparam int WEIGHT_FRAC = WEIGHT_BITS - 2;
  localparam int SAMP_FRAC   = SAMPLE_BITS - 1;
  localparam int MU_BITS     = 16;
  localparam int UPD_SHIFT   = MU_BITS + 2 * SAMP_FRAC - WEIGHT_FRAC;
  localparam int COEF_FRAC   = 20;
  localparam int COEF_W      = 21;
  localparam int HALF_LEN    = 64;
  localparam int ACC_W       = WEIGHT_BITS + SAMPLE_BITS + 8;
  localparam int MA_W        = MU_BITS + SAMPLE_BITS + 1;
  localparam int PROD_W      = MA_W + SAMPLE_BITS;
  localparam int SAT_IN_W    = 40;
  localparam int IN_TDATA_W  = 2 * SAMPLE_BITS;
  localparam int OUT_TDATA_W = 3 * SAMPLE_BITS;

  localparam logic [MU_BITS-1:0] STEP_RESET = MU_BITS'(655);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_RND,
    ST_SAT,
    ST_MUL,
    ST_LDM,
    ST_UPD,
    ST_HIL,
    ST_FIN
  } st_t;

  // magnitudes of taps 0..63, Q0.20
  localparam logic [19:0] COEF_MAG [HALF_LEN] = '{
    20'd14, 20'd2, 20'd24, 20'd6, 20'd44, 20'd14, 20'd74, 20'd26,
    20'd119, 20'd46, 20'd181, 20'd75, 20'd267, 20'd118, 20'd382, 20'd179,
    20'd532, 20'd263, 20'd725, 20'd376, 20'd969, 20'd526, 20'd1273, 20'd722,
    20'd1648, 20'd972, 20'd2104, 20'd1290, 20'd2655, 20'd1688, 20'd3313, 20'd2182,
    20'd4094, 20'd2790, 20'd5017, 20'd3535, 20'd6102, 20'd4442, 20'd7377, 20'd5545,
    20'd8874, 20'd6887, 20'd10638, 20'd8524, 20'd12732, 20'd10536, 20'd15244, 20'd13037,
    20'd18313, 20'd16205, 20'd22156, 20'd20328, 20'd27148, 20'd25914, 20'd33982, 20'd33951,
    20'd44098, 20'd46642, 20'd61042, 20'd70119, 20'd96486, 20'd130150, 20'd224399, 20'd664911
  };

  // antisymmetric: first half negative, second half mirrored positive
  function automatic logic signed [COEF_W-1:0] hilbert_coef(input logic [6:0] k);
    logic signed [COEF_W-1:0] mag;
    if (k[6] == 1'b0) begin
      mag = $signed({1'b0, COEF_MAG[k[5:0]]});
      return -mag;
    end else begin
      mag = $signed({1'b0, COEF_MAG[~k[5:0]]});
      return mag;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - SAT_IN_W'(1);
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end else begin
      return v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

FILE: src/lms_adaptive_filter_hilbert_top.sv
// Top level of the LMS adaptive noise canceller with Hilbert-shifted anti-noise output.
//
//  channel | ports                           | word fields, low bit up
//  --------+---------------------------------+----------------------------------------------
//  input   | in_tvalid/in_tready/in_tdata    | reference_sample, measured_sample (16b each)
//  output  | out_tvalid/out_tready/out_tdata | error_sample, cancel_sample,
//          |                                 | shifted_cancel (16b each)
//  config  | cfg_wr_en/cfg_wr_data           | step_size (16b unsigned Q0.16)
//
//  Each word is worked in three passes over the taps through one shared multiplier:
//  estimate, weight update, Hilbert.
//  in_tready is high only between words; the finished result waits in the output register
//  while the next word is accepted, and the last step holds if that register is still full.
//  rst_n is synchronous: weights and both histories read as zero until written again.
module lms_adaptive_filter_hilbert_top #(
  parameter int TAPS = lmsh_pkg::TAPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lmsh_pkg::IN_TDATA_W-1:0]    in_tdata,   // reference_sample, measured_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lmsh_pkg::OUT_TDATA_W-1:0]   out_tdata,  // error, cancel, shifted_cancel
  input  logic                               cfg_wr_en,
  input  logic [lmsh_pkg::MU_BITS-1:0]       cfg_wr_data // step_size
);
  import lmsh_pkg::*;

  localparam int PW = (TAPS > 1) ? $clog2(TAPS) : 1;  // history / weight index
  localparam int CW = $clog2(TAPS + 2);               // pass counter incl. drain
  localparam int Y_W = ACC_W - WEIGHT_FRAC;
  localparam int H_W = ACC_W - COEF_FRAC;
  localparam int D_W = PROD_W - UPD_SHIFT;
  localparam int WS_W = WEIGHT_BITS + 2;

  // sequencer
  st_t state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic          pass_st, pass_end, issue;
  logic          in_acc, out_load;

  // pointers and fill flags
  logic [PW-1:0] wp_r, rd_ptr_r, rd_ptr_nxt, wp_nxt;
  logic          full_r, wt_init_r;
  logic [MU_BITS-1:0] step_r;

  // pipeline
  logic          s1_v_r, s2_v_r, hv_r;
  logic [PW-1:0] s1_idx_r, s2_idx_r;
  logic signed [COEF_W-1:0]      coef_r;
  logic signed [MA_W-1:0]        mul_a, mu_e_r;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      prod, p_r;
  logic signed [WEIGHT_BITS-1:0] w_op, w_d_r;
  logic signed [SAMPLE_BITS-1:0] x_op, a_op;
  logic signed [ACC_W-1:0]       acc_r;

  // per-word values
  logic signed [SAMPLE_BITS-1:0] meas_r, err_r, anti_c, err_c, shifted_c;
  logic signed [Y_W-1:0]         y_r;

  // arithmetic temporaries
  logic signed [ACC_W-1:0]       y_rnd, h_rnd;
  logic signed [PROD_W-1:0]      d_rnd;
  logic signed [D_W-1:0]         delta;
  logic signed [WS_W-1:0]        wsum;
  logic signed [WEIGHT_BITS-1:0] w_new;
  logic signed [Y_W-1:0]         y_c;
  logic signed [H_W-1:0]         h_c;

  // RAM ports
  logic                          wt_we, ref_we, an_we;
  logic [WEIGHT_BITS-1:0]        wt_q;
  logic [SAMPLE_BITS-1:0]        ref_q, an_q;

  lmsh_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(TAPS)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (s2_idx_r),
    .wdata (w_new),
    .raddr (cnt_r[PW-1:0]),
    .rdata (wt_q)
  );

  lmsh_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (wp_r),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .raddr (rd_ptr_r),
    .rdata (ref_q)
  );

  lmsh_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_an_ram (
    .clk   (clk),
    .we    (an_we),
    .waddr (wp_r),
    .wdata (anti_c),
    .raddr (rd_ptr_r),
    .rdata (an_q)
  );

  // control outputs of the sequencer
  always_comb begin
    pass_st   = (state_r == ST_MAC) || (state_r == ST_UPD) || (state_r == ST_HIL);
    pass_end  = pass_st && (cnt_r == CW'(TAPS + 1));
    issue     = pass_st && (cnt_r < CW'(TAPS));
    in_tready = (state_r == ST_IDLE);
    in_acc    = in_tvalid && in_tready;
    ref_we    = in_acc;
    an_we     = (state_r == ST_SAT);
    wt_we     = (state_r == ST_UPD) && s2_v_r;
    out_load  = (state_r == ST_FIN) && (!out_tvalid || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (pass_end) state_nxt = ST_RND;
      end
      ST_RND:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_LDM;
      ST_LDM:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (pass_end) state_nxt = ST_HIL;
      end
      ST_HIL: begin
        if (pass_end) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pointer steps: history reads walk backward from the newest entry
  always_comb begin
    rd_ptr_nxt = (rd_ptr_r == '0) ? PW'(TAPS - 1) : rd_ptr_r - 1'b1;
    wp_nxt     = (wp_r == PW'(TAPS - 1)) ? '0 : wp_r + 1'b1;
  end

  // operand select for the shared multiplier; unwritten entries read as zero
  always_comb begin
    w_op = wt_init_r ? $signed(wt_q) : '0;
    x_op = hv_r ? $signed(ref_q) : '0;
    a_op = hv_r ? $signed(an_q) : '0;
    case (state_r)
      ST_MAC: begin
        mul_a = MA_W'(w_op);
        mul_b = x_op;
      end
      ST_UPD: begin
        mul_a = mu_e_r;
        mul_b = x_op;
      end
      ST_HIL: begin
        mul_a = MA_W'(coef_r);
        mul_b = a_op;
      end
      ST_MUL: begin
        mul_a = MA_W'($signed({1'b0, step_r}));
        mul_b = err_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // rounding, saturation and weight update
  always_comb begin
    y_rnd  = acc_r + ACC_W'(64'sd1 <<< (WEIGHT_FRAC - 1));
    y_c    = y_rnd[ACC_W-1:WEIGHT_FRAC];
    err_c  = sat_sample(SAT_IN_W'(meas_r) - SAT_IN_W'(y_r));
    anti_c = sat_sample(-SAT_IN_W'(y_r));
    h_rnd  = acc_r + ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
    h_c    = h_rnd[ACC_W-1:COEF_FRAC];
    shifted_c = sat_sample(SAT_IN_W'(h_c));
    d_rnd  = p_r + PROD_W'(64'sd1 <<< (UPD_SHIFT - 1));
    delta  = d_rnd[PROD_W-1:UPD_SHIFT];
    wsum   = WS_W'(w_d_r) + WS_W'(delta);
    if (wsum[WS_W-1:WEIGHT_BITS-1] == '0 || wsum[WS_W-1:WEIGHT_BITS-1] == '1) begin
      w_new = wsum[WEIGHT_BITS-1:0];
    end else if (wsum[WS_W-1]) begin
      w_new = {1'b1, {(WEIGHT_BITS - 1){1'b0}}};
    end else begin
      w_new = {1'b0, {(WEIGHT_BITS - 1){1'b1}}};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      wp_r       <= '0;
      full_r     <= 1'b0;
      wt_init_r  <= 1'b0;
      step_r     <= STEP_RESET;
      out_tvalid <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (pass_st && !pass_end) ? cnt_r + 1'b1 : '0;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (cfg_wr_en) step_r <= cfg_wr_data;
      // every weight has been written once the first update pass is done
      if (state_r == ST_UPD && pass_end) wt_init_r <= 1'b1;
      if (out_load) begin
        wp_r <= wp_nxt;
        if (wp_r == PW'(TAPS - 1)) full_r <= 1'b1;
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) meas_r <= $signed(in_tdata[IN_TDATA_W-1:SAMPLE_BITS]);
    // restart the backward walk at the newest entry outside the passes
    rd_ptr_r <= pass_st ? (issue ? rd_ptr_nxt : rd_ptr_r) : wp_r;
    s1_idx_r <= cnt_r[PW-1:0];
    s2_idx_r <= s1_idx_r;
    hv_r     <= full_r || (rd_ptr_r <= wp_r);
    coef_r   <= hilbert_coef(7'(cnt_r[PW-1:0]));
    p_r      <= prod;
    w_d_r    <= w_op;
    if (state_r == ST_IDLE || state_r == ST_UPD) begin
      acc_r <= '0;
    end else if ((state_r == ST_MAC || state_r == ST_HIL) && s2_v_r) begin
      acc_r <= acc_r + ACC_W'(p_r);
    end
    if (state_r == ST_RND) y_r <= y_c;
    if (state_r == ST_SAT) err_r <= err_c;
    if (state_r == ST_LDM) mu_e_r <= p_r[MA_W-1:0];
    if (out_load) out_tdata <= {shifted_c, anti_c, err_r};
  end

`ifndef SYNTHESIS
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_MAC))
    else $error("accepted word did not start the estimate pass");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> ($past(state_r) == ST_FIN))
    else $error("result appeared outside the final step");

  a_wt_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    wt_we |-> (cnt_r >= CW'(2)))
    else $error("weight written before the update pipeline filled");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TAPS + 1))
    else $error("pass counter ran past the drain");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PW'(TAPS - 1))
    else $error("write pointer out of range");
`endif

endmodule

FILE: src/lmsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
